[rtl/ihsp_pkg.sv]
// Shared types and constants for the image header size parser.
`timescale 1ns / 1ps

package ihsp_pkg;

    // Width of the byte position counter within one file.
    localparam int POSITION_BITS = 32;
    // Target positions carry one extra bit so that a jump past the limit never matches.
    localparam int TARGET_BITS   = POSITION_BITS + 1;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] SOF_BASELINE      = 8'hC0;
    localparam int         JPEG_FIRST_LENGTH = 4;
    localparam int         PNG_SIZE_OFFSET   = 16;
    localparam int         BMP_SIZE_OFFSET   = 18;
    localparam int         SOF_SIZE_SKIP     = 5;
    localparam int         MIN_SEG_LENGTH    = 2;

    typedef enum logic [1:0] {
        FMT_JPEG = 2'd0,
        FMT_PNG  = 2'd1,
        FMT_BMP  = 2'd2
    } t_image_format;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_MALFORMED = 2'd2
    } t_parse_status;

    // One result request as it travels from the parser to the output buffer.
    typedef struct packed {
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
        t_parse_status        status;
    } t_result;

endpackage

[rtl/image_header_size_parser.sv]
// Top level of the image header size parser.
`timescale 1ns / 1ps

// Takes an image file one byte per request, in file order, with i_last_byte on the final
// byte, and gives at most one result per file: width, height and status (ok, truncated,
// or malformed JPEG segment length). The format register (0 JPEG, 1 PNG, 2 BMP) is
// sampled at the first byte of each file; write it only between files. The block takes
// one byte every clock cycle: each byte costs one position compare and one add in the
// parser, done between the parser state registers and a two-entry output buffer. A
// result is written into the output buffer and shown from its head entry. The input
// stalls only while both output buffer entries are held by a stalled downstream side.
// No clearing pass is needed after reset.
module image_header_size_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic [1:0]  o_parse_status
);
    import ihsp_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    buf_full;
    t_result parse_result;
    t_result out_result;

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    // Header parser.
    ihsp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_res_valid   (res_valid),
        .o_result      (parse_result)
    );

    // Result buffer toward the downstream side.
    ihsp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_result (parse_result),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_image_width  = out_result.width;
    assign o_image_height = out_result.height;
    assign o_parse_status = out_result.status;

endmodule

[rtl/ihsp_parse.sv]
// Byte-by-byte header parser: position tracking, JPEG segment walk and size gathering.
`timescale 1ns / 1ps

module ihsp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_wr_data,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output ihsp_pkg::t_result o_result
);
    import ihsp_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_MARK,
        PH_GATHER,
        PH_IDLE,
        PH_DONE
    } t_phase;

    logic [1:0]               r_image_format;
    logic [1:0]               r_fmt;
    t_phase                   r_phase;
    logic [POSITION_BITS-1:0] r_pos;
    logic [TARGET_BITS-1:0]   r_target;
    logic [7:0]               r_len_hi;
    logic                     r_need8;
    logic [3:0]               r_gcnt;
    logic [7:0]               r_gathered [8];

    logic [1:0]               n_fmt;
    t_phase                   n_phase;
    logic [POSITION_BITS-1:0] n_pos;
    logic [TARGET_BITS-1:0]   n_target;
    logic [7:0]               n_len_hi;
    logic                     n_need8;
    logic [3:0]               n_gcnt;
    logic [7:0]               n_gathered [8];

    logic [1:0]               fmt;
    t_phase                   ph;
    logic [TARGET_BITS-1:0]   tgt;
    logic                     need8;
    logic [3:0]               gcnt;
    logic [TARGET_BITS-1:0]   cur_ext;
    logic [15:0]              seg_len;
    logic                     in_range;
    logic                     hit;
    logic                     res_hit;
    t_result                  res;

    assign cur_ext  = {1'b0, r_pos};
    assign in_range = (r_pos != {POSITION_BITS{1'b1}});
    assign seg_len  = {r_len_hi, i_data_byte};

    // Next-state logic for one accepted byte.
    always_comb begin
        fmt   = r_fmt;
        ph    = r_phase;
        tgt   = r_target;
        need8 = r_need8;
        gcnt  = r_gcnt;

        // The first byte of a file latches the format and sets the first position of interest.
        if (r_phase == PH_START) begin
            fmt  = r_image_format;
            gcnt = '0;
            case (fmt)
                FMT_JPEG: begin
                    ph  = PH_LEN_HI;
                    tgt = TARGET_BITS'(JPEG_FIRST_LENGTH);
                end
                FMT_PNG: begin
                    ph    = PH_GATHER;
                    tgt   = TARGET_BITS'(PNG_SIZE_OFFSET);
                    need8 = 1'b1;
                end
                FMT_BMP: begin
                    ph    = PH_GATHER;
                    tgt   = TARGET_BITS'(BMP_SIZE_OFFSET);
                    need8 = 1'b1;
                end
                default: begin
                    ph = PH_IDLE;
                end
            endcase
        end

        n_fmt      = fmt;
        n_phase    = ph;
        n_target   = tgt;
        n_need8    = need8;
        n_gcnt     = gcnt;
        n_len_hi   = r_len_hi;
        n_gathered = r_gathered;
        n_pos      = r_pos;
        res_hit    = 1'b0;
        res        = '{width: '0, height: '0, status: ST_OK};

        hit = in_range && (cur_ext == tgt);

        if (hit) begin
            case (ph)
                PH_LEN_HI: begin
                    n_len_hi = i_data_byte;
                    n_phase  = PH_LEN_LO;
                    n_target = cur_ext + TARGET_BITS'(1);
                end
                PH_LEN_LO: begin
                    // A segment length shorter than its own length field is malformed.
                    if (seg_len < 16'(MIN_SEG_LENGTH)) begin
                        res_hit    = 1'b1;
                        res.status = ST_MALFORMED;
                        n_phase    = PH_DONE;
                    end else begin
                        n_phase  = PH_MARK;
                        n_target = cur_ext + TARGET_BITS'(seg_len);
                    end
                end
                PH_MARK: begin
                    if (i_data_byte == SOF_BASELINE) begin
                        n_phase  = PH_GATHER;
                        n_target = cur_ext + TARGET_BITS'(SOF_SIZE_SKIP - 1);
                        n_need8  = 1'b0;
                        n_gcnt   = '0;
                    end else begin
                        n_phase  = PH_LEN_HI;
                        n_target = cur_ext + TARGET_BITS'(1);
                    end
                end
                PH_GATHER: begin
                    if (gcnt < 4'd8) begin
                        n_gathered[gcnt[2:0]] = i_data_byte;
                    end
                    n_gcnt   = gcnt + 4'd1;
                    n_target = cur_ext + TARGET_BITS'(1);
                    if (n_gcnt >= (need8 ? 4'd8 : 4'd4)) begin
                        res_hit = 1'b1;
                        n_phase = PH_DONE;
                        case (fmt)
                            FMT_JPEG: begin
                                res.height = {16'd0, n_gathered[0], n_gathered[1]};
                                res.width  = {16'd0, n_gathered[2], n_gathered[3]};
                            end
                            FMT_PNG: begin
                                res.width  = {n_gathered[0], n_gathered[1],
                                              n_gathered[2], n_gathered[3]};
                                res.height = {n_gathered[4], n_gathered[5],
                                              n_gathered[6], n_gathered[7]};
                            end
                            default: begin
                                res.width  = {n_gathered[3], n_gathered[2],
                                              n_gathered[1], n_gathered[0]};
                                res.height = {n_gathered[7], n_gathered[6],
                                              n_gathered[5], n_gathered[4]};
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        // The final byte reports truncation if no result came out, then starts a new file.
        if (i_last_byte) begin
            if ((n_phase != PH_DONE) && !res_hit) begin
                res_hit    = 1'b1;
                res.status = ST_TRUNCATED;
            end
            n_pos    = '0;
            n_fmt    = '0;
            n_phase  = PH_START;
            n_target = '0;
            n_len_hi = '0;
            n_gcnt   = '0;
            n_need8  = 1'b0;
        end else if (in_range) begin
            n_pos = r_pos + POSITION_BITS'(1);
        end
    end

    assign o_res_valid = i_accept && res_hit;
    assign o_result    = res;

    // Configuration register and per-file parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_format <= '0;
            r_fmt          <= '0;
            r_phase        <= PH_START;
            r_pos          <= '0;
            r_target       <= '0;
            r_len_hi       <= '0;
            r_need8        <= 1'b0;
            r_gcnt         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_image_format <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_fmt    <= n_fmt;
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_target <= n_target;
                r_len_hi <= n_len_hi;
                r_need8  <= n_need8;
                r_gcnt   <= n_gcnt;
            end
        end
    end

    // Gathered size bytes are payload and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_gathered <= n_gathered;
        end
    end

endmodule

[rtl/ihsp_out_buf.sv]
// Two-entry output buffer that decouples parser results from downstream stalls.
`timescale 1ns / 1ps

module ihsp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihsp_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output ihsp_pkg::t_result o_result
);
    import ihsp_pkg::*;

    t_result    r_head;
    t_result    r_tail;
    logic [1:0] r_count;
    logic       pop;

    assign pop      = (r_count != 2'd0) && !i_stall;
    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign o_result = r_head;

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry data moves from tail to head as the head request is taken.
    always_ff @(posedge i_clk) begin
        case (r_count)
            2'd0: begin
                if (i_push) begin
                    r_head <= i_result;
                end
            end
            2'd1: begin
                if (i_push && pop) begin
                    r_head <= i_result;
                end else if (i_push) begin
                    r_tail <= i_result;
                end
            end
            default: begin
                if (pop) begin
                    r_head <= r_tail;
                end
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("request pushed into a full output buffer");

    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd0) |=> (o_valid && r_head == $past(i_result)))
        else $error("pushed request did not reach the head");

    a_tail_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_count == 2'd2) |=> (o_valid && r_head == $past(r_tail)))
        else $error("tail request did not move to the head");
`endif

endmodule
